/* rtl/sit_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted insert table package
// Shared sizes, codes and transaction types for the sorted table with search.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int DEPTH = 64;
    localparam int KEY_W = 32;
    localparam int PAY_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sort_key;
        logic [31:0] entry_payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_payload;
        logic [6:0]  entry_count;
    } t_out_item;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             acc;
        logic             ins;
        logic             srch;
        logic             clr;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_cell_ctl;

endpackage

/* rtl/sit_cell.sv */
// ----------------------------------------------------------------------------
// Sorted insert table cell
// Holds one entry; shifts toward higher index on insert and flags a first match.
// ----------------------------------------------------------------------------
module sit_cell
    import sit_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic             i_prev_valid,
    input  logic             i_prev_take,
    input  logic             i_prev_eq,
    input  logic [KEY_W-1:0] i_prev_key,
    input  logic [PAY_W-1:0] i_prev_payload,
    output logic             o_valid,
    output logic             o_take,
    output logic             o_eq,
    output logic [KEY_W-1:0] o_key,
    output logic [PAY_W-1:0] o_payload,
    output logic             o_hit,
    output logic [PAY_W-1:0] o_hit_payload
);

    logic             r_valid;
    logic             n_valid;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_payload;
    logic             r_hit;
    logic [PAY_W-1:0] r_hit_payload;
    logic             w_first;

    // Keys are ascending and valid entries are packed low, so the take flag
    // is zero below the insertion point and one from there on.
    assign o_take  = !r_valid || (r_key > i_ctl.key);
    assign o_eq    = r_valid && (r_key == i_ctl.key);
    assign w_first = o_eq && !i_prev_eq;

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (i_ctl.ins) begin
            n_valid = r_valid | i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctl.acc) begin
                r_hit <= i_ctl.srch && w_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && o_take) begin
            if (i_prev_take) begin
                r_key     <= i_prev_key;
                r_payload <= i_prev_payload;
            end else begin
                r_key     <= i_ctl.key;
                r_payload <= i_ctl.payload;
            end
        end
        if (i_ctl.acc) begin
            r_hit_payload <= (i_ctl.srch && w_first) ? r_payload : '0;
        end
    end

    assign o_valid       = r_valid;
    assign o_key         = r_key;
    assign o_payload     = r_payload;
    assign o_hit         = r_hit;
    assign o_hit_payload = r_hit_payload;

endmodule

/* rtl/sorted_insert_table_with_search.sv */
// ----------------------------------------------------------------------------
// Sorted insert table with search
// Ascending key table built as a row of cells, with clear, insert and search.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_in_valid, o_in_ready, i_in_data) carries one
// transaction per item: clear, insert or key search. The output channel
// (o_out_valid, i_out_ready, o_out_data) returns exactly one result per item,
// in order: status, found payload and the entry count after the item.
// Throughput is one item per cycle unless the receiver stalls: every cell
// compares its key against the broadcast key and shifts from its neighbor in
// the same cycle; an OR tree merges the first-match payloads into the output.
// A stalled receiver holds the output register; one more item may sit in the
// search stage, after which o_in_ready drops until the output drains.
// Reset empties the table at once (cell valid bits and the count clear); the
// stored keys and payloads themselves are not cleared.
// An insert into a full table is refused with overflow status; an unused kind
// code leaves the table alone and reports ok.
// ----------------------------------------------------------------------------
module sorted_insert_table_with_search
    import sit_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_cell_ctl        w_ctl;
    logic             w_acc;
    logic             w_full;
    logic             w_s1_adv;
    logic             w_found;
    logic [PAY_W-1:0] w_found_pay;

    logic             w_valid    [DEPTH];
    logic             w_take     [DEPTH];
    logic             w_eq       [DEPTH];
    logic [KEY_W-1:0] w_key      [DEPTH];
    logic [PAY_W-1:0] w_pay      [DEPTH];
    logic             w_hit      [DEPTH];
    logic [PAY_W-1:0] w_hit_pay  [DEPTH];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_s1_vld;
    logic             r_s1_ovf;
    logic             r_s1_srch;
    logic [CNT_W-1:0] r_s1_count;
    logic             r_out_vld;
    t_out_item        r_out;

    assign w_s1_adv   = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || w_s1_adv;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));

    always_comb begin
        w_ctl.acc     = w_acc;
        w_ctl.ins     = w_acc && (i_in_data.kind == KIND_INSERT) && !w_full;
        w_ctl.srch    = (i_in_data.kind == KIND_SEARCH);
        w_ctl.clr     = w_acc && (i_in_data.kind == KIND_CLEAR);
        w_ctl.key     = i_in_data.sort_key[KEY_W-1:0];
        w_ctl.payload = i_in_data.entry_payload[PAY_W-1:0];
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.clr) begin
            n_count = '0;
        end else if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                sit_cell u_cell (
                    .i_clk          (i_clk),
                    .i_rst_n        (i_rst_n),
                    .i_ctl          (w_ctl),
                    .i_prev_valid   (1'b1),
                    .i_prev_take    (1'b0),
                    .i_prev_eq      (1'b0),
                    .i_prev_key     (w_ctl.key),
                    .i_prev_payload (w_ctl.payload),
                    .o_valid        (w_valid[g]),
                    .o_take         (w_take[g]),
                    .o_eq           (w_eq[g]),
                    .o_key          (w_key[g]),
                    .o_payload      (w_pay[g]),
                    .o_hit          (w_hit[g]),
                    .o_hit_payload  (w_hit_pay[g])
                );
            end else begin : g_body
                sit_cell u_cell (
                    .i_clk          (i_clk),
                    .i_rst_n        (i_rst_n),
                    .i_ctl          (w_ctl),
                    .i_prev_valid   (w_valid[g-1]),
                    .i_prev_take    (w_take[g-1]),
                    .i_prev_eq      (w_eq[g-1]),
                    .i_prev_key     (w_key[g-1]),
                    .i_prev_payload (w_pay[g-1]),
                    .o_valid        (w_valid[g]),
                    .o_take         (w_take[g]),
                    .o_eq           (w_eq[g]),
                    .o_key          (w_key[g]),
                    .o_payload      (w_pay[g]),
                    .o_hit          (w_hit[g]),
                    .o_hit_payload  (w_hit_pay[g])
                );
            end
        end
    endgenerate

    // At most one cell flags a first match, so an OR merge picks its payload.
    always_comb begin
        w_found     = 1'b0;
        w_found_pay = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_found     = w_found | w_hit[i];
            w_found_pay = w_found_pay | w_hit_pay[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_ovf   <= (i_in_data.kind == KIND_INSERT) && w_full;
            r_s1_srch  <= (i_in_data.kind == KIND_SEARCH);
            r_s1_count <= n_count;
        end
        if (w_s1_adv) begin
            if (r_s1_ovf) begin
                r_out.status <= ST_OVERFLOW;
            end else if (r_s1_srch && !w_found) begin
                r_out.status <= ST_NOT_FOUND;
            end else begin
                r_out.status <= ST_OK;
            end
            r_out.found_payload <= 32'(w_found_pay);
            r_out.entry_count   <= 7'(r_s1_count);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

/* bench/sit_table_monitor.sv */
// ----------------------------------------------------------------------------
// Sorted insert table monitor
// Watches both channels of the sorted table, keeps its own copy of the table
// and compares every result against the outcome expected for its transaction.
// ----------------------------------------------------------------------------
module sit_table_monitor
    import sit_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int REPORT_LIMIT = 10;

    logic [KEY_W-1:0] table_keys [DEPTH];
    logic [PAY_W-1:0] table_pays [DEPTH];
    int               table_fill;
    t_out_item        pending_results [$];
    int               mismatches = 0;

    // Applies one transaction to the local table and returns the result it
    // should produce.
    function automatic t_out_item apply_to_table(input t_in_item it);
        t_out_item res;
        int        pos;
        logic      hit;
        res = '0;
        res.status = ST_OK;
        hit = 1'b0;
        case (it.kind)
            KIND_CLEAR: begin
                table_fill = 0;
            end
            KIND_INSERT: begin
                if (table_fill >= DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    // The new entry goes before the first strictly greater key.
                    pos = table_fill;
                    for (int i = table_fill - 1; i >= 0; i--) begin
                        if (table_keys[i] > it.sort_key) pos = i;
                    end
                    for (int i = table_fill; i > pos; i--) begin
                        table_keys[i] = table_keys[i-1];
                        table_pays[i] = table_pays[i-1];
                    end
                    table_keys[pos] = it.sort_key;
                    table_pays[pos] = it.entry_payload;
                    table_fill++;
                end
            end
            KIND_SEARCH: begin
                // Scanning downward leaves the lowest matching index.
                for (int i = table_fill - 1; i >= 0; i--) begin
                    if (table_keys[i] == it.sort_key) begin
                        res.found_payload = table_pays[i];
                        hit = 1'b1;
                    end
                end
                if (!hit) res.status = ST_NOT_FOUND;
            end
            default: begin
            end
        endcase
        res.entry_count = 7'(table_fill);
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, what, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            table_fill = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("[%0t] result with no transaction outstanding: %p",
                                 $time, i_out_data);
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_data.status !== want.status)
                        flag_mismatch("status", 32'(want.status),
                                      32'(i_out_data.status));
                    if (i_out_data.found_payload !== want.found_payload)
                        flag_mismatch("found_payload", want.found_payload,
                                      i_out_data.found_payload);
                    if (i_out_data.entry_count !== want.entry_count)
                        flag_mismatch("entry_count", 32'(want.entry_count),
                                      32'(i_out_data.entry_count));
                end
            end
            if (i_in_valid && i_in_ready)
                pending_results.push_back(apply_to_table(i_in_data));
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_results.size();
    end

endmodule

/* bench/tb_sorted_insert_table_with_search.sv */
// ----------------------------------------------------------------------------
// Sorted insert table testbench
// Drives clear, insert, search and unused-kind transactions into the sorted table, first
// a directed set of corner cases and then random fill sessions, under several
// patterns of sender gaps and receiver stalls. A monitor checks the results.
// ----------------------------------------------------------------------------
module tb_sorted_insert_table_with_search;
    import sit_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1950;
    localparam int PHASE_LEN   = 160;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 20;

    typedef enum int {KEYS_FEW, KEYS_WIDE, KEYS_NEAR, KEYS_EDGE} t_key_mode;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        pending;

    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        cur_phase = -1;
    logic      hold_toggle = 1'b0;
    logic      hold_seen = 1'b0;
    int        hold_left = 0;
    int        items_sent = 0;
    logic [KEY_W-1:0] live_keys [$];

    sorted_insert_table_with_search uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    sit_table_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 clk = ~clk;

    // A toggle of hold_toggle starts a long stretch with the output blocked.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input t_in_item it);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic issue(input logic [1:0] kind, input logic [31:0] key,
                         input logic [31:0] pay);
        t_in_item it;
        int       phase;
        phase = (items_sent / PHASE_LEN) % 4;
        if (phase != cur_phase) begin
            cur_phase = phase;
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                    // Full-rate sender against a blocked receiver fills the block.
                    hold_toggle <= ~hold_toggle;
                end
                1: begin
                    send_idle_pct = 87;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 87;
                end
                default: begin
                    send_idle_pct = 9;
                    recv_stall_pct <= 9;
                end
            endcase
        end
        it.kind          = kind;
        it.sort_key      = key;
        it.entry_payload = pay;
        if (kind == KIND_CLEAR)
            live_keys.delete();
        else if (kind == KIND_INSERT && live_keys.size() < DEPTH)
            live_keys.push_back(key);
        send_item(it);
    endtask

    function automatic logic [31:0] pick_key(input t_key_mode mode,
                                             input logic [31:0] base);
        logic [31:0] k;
        case (mode)
            KEYS_FEW:  k = $urandom_range(7);
            KEYS_WIDE: k = $urandom;
            KEYS_NEAR: k = base + $urandom_range(31);
            default: begin
                case ($urandom_range(3))
                    0:       k = '0;
                    1:       k = '1;
                    2:       k = 32'hFFFF_FFFF - $urandom_range(3);
                    default: k = $urandom;
                endcase
            end
        endcase
        return k;
    endfunction

    function automatic logic [31:0] search_key(input t_key_mode mode,
                                               input logic [31:0] base);
        if (live_keys.size() != 0 && $urandom_range(99) < 70)
            return live_keys[$urandom_range(live_keys.size() - 1)];
        return pick_key(mode, base);
    endfunction

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        t_key_mode   mode;
        logic [31:0] base;
        int          n_ins;
        int          waited;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corner cases: empty table, extreme keys, equal keys kept in
        // arrival order, missing keys and the unused kind code.
        issue(KIND_SEARCH, 32'd0, 32'hFFFF_FFFF);
        issue(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(KIND_INSERT, 32'd0, 32'd0);
        issue(KIND_INSERT, 32'd5, 32'h0000_000A);
        issue(KIND_INSERT, 32'd5, 32'h0000_000B);
        issue(KIND_INSERT, 32'd5, 32'h0000_000C);
        issue(KIND_INSERT, 32'd3, 32'h0000_1234);
        issue(KIND_SEARCH, 32'd5, 32'd0);
        issue(KIND_SEARCH, 32'hFFFF_FFFF, 32'd0);
        issue(KIND_SEARCH, 32'd0, 32'd0);
        issue(KIND_SEARCH, 32'd4, 32'd0);
        issue(KIND_SEARCH, 32'hFFFF_FFFE, 32'd0);
        issue(KIND_UNUSED, 32'd5, 32'h5555_5555);
        issue(KIND_INSERT, 32'h8000_0000, 32'h5555_5555);
        issue(KIND_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
        issue(KIND_SEARCH, 32'h8000_0000, 32'd0);
        issue(KIND_SEARCH, 32'h7FFF_FFFF, 32'd0);
        issue(KIND_CLEAR, 32'd0, 32'd0);
        issue(KIND_SEARCH, 32'd5, 32'd0);
        issue(KIND_UNUSED, 32'd0, 32'd0);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(5, 20))
                    issue(2'($urandom_range(3)), $urandom, $urandom);
            end else begin
                mode = t_key_mode'($urandom_range(3));
                base = $urandom;
                if ($urandom_range(99) < 80) issue(KIND_CLEAR, $urandom, $urandom);
                // About a quarter of the sessions run past a full table.
                n_ins = ($urandom_range(3) == 0) ? $urandom_range(64, 72)
                                                 : $urandom_range(1, 63);
                repeat (n_ins) begin
                    while ($urandom_range(99) < 40)
                        issue(KIND_SEARCH, search_key(mode, base), $urandom);
                    issue(KIND_INSERT, pick_key(mode, base), $urandom);
                end
                repeat ($urandom_range(2, 8))
                    issue(KIND_SEARCH, search_key(mode, base), $urandom);
            end
        end

        in_valid <= 1'b0;
        recv_stall_pct <= 0;
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sorted_insert_table_with_search.f */
rtl/sit_pkg.sv
rtl/sit_cell.sv
rtl/sorted_insert_table_with_search.sv
bench/sit_table_monitor.sv
bench/tb_sorted_insert_table_with_search.sv
